[hw/rtl/stt_pkg.sv]
// Shared types, constants, character-class and operator-kind functions of the source text tokenizer.
`default_nettype none

package stt_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KIND_W   = 5;
   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned ROW_W    = 20;
   localparam int unsigned COL_W    = 16;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [ROW_W-1:0] ROW_MAX = '1;
   localparam logic [COL_W-1:0] COL_MAX = '1;

   localparam int unsigned FIFO_DEPTH = 4;

   localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_BANG    = 8'h21;
   localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
   localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
   localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_EQ      = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_BAR     = 8'h7C;

   localparam logic [KIND_W-1:0] KIND_NONE       = 5'd0;
   localparam logic [KIND_W-1:0] KIND_END        = 5'd0;
   localparam logic [KIND_W-1:0] KIND_SINGLE     = 5'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd2;
   localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd3;
   localparam logic [KIND_W-1:0] KIND_STRING     = 5'd4;
   localparam logic [KIND_W-1:0] KIND_CHAR       = 5'd5;
   localparam logic [KIND_W-1:0] KIND_ARROW      = 5'd6;
   localparam logic [KIND_W-1:0] KIND_DBL_COLON  = 5'd7;
   localparam logic [KIND_W-1:0] KIND_DBL_PLUS   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_DBL_MINUS  = 5'd9;
   localparam logic [KIND_W-1:0] KIND_DBL_LT     = 5'd10;
   localparam logic [KIND_W-1:0] KIND_DBL_GT     = 5'd11;
   localparam logic [KIND_W-1:0] KIND_DBL_EQ     = 5'd12;
   localparam logic [KIND_W-1:0] KIND_DBL_AMP    = 5'd13;
   localparam logic [KIND_W-1:0] KIND_DBL_BAR    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_EQ_LT      = 5'd15;
   localparam logic [KIND_W-1:0] KIND_EQ_GT      = 5'd16;
   localparam logic [KIND_W-1:0] KIND_EQ_BANG    = 5'd17;
   localparam logic [KIND_W-1:0] KIND_EQ_PLUS    = 5'd18;
   localparam logic [KIND_W-1:0] KIND_EQ_MINUS   = 5'd19;
   localparam logic [KIND_W-1:0] KIND_EQ_STAR    = 5'd20;
   localparam logic [KIND_W-1:0] KIND_EQ_SLASH   = 5'd21;
   localparam logic [KIND_W-1:0] KIND_EQ_PERCENT = 5'd22;
   localparam logic [KIND_W-1:0] KIND_EQ_AMP     = 5'd23;
   localparam logic [KIND_W-1:0] KIND_EQ_CARET   = 5'd24;
   localparam logic [KIND_W-1:0] KIND_EQ_BAR     = 5'd25;

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_IDENT      = 4'd1,
      MODE_NUMBER     = 4'd2,
      MODE_STR        = 4'd3,
      MODE_STR_ESC    = 4'd4,
      MODE_CHR        = 4'd5,
      MODE_CHR_ESC    = 4'd6,
      MODE_OP         = 4'd7,
      MODE_LINE       = 4'd8,
      MODE_BLOCK      = 4'd9,
      MODE_BLOCK_STAR = 4'd10
   } mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   char_byte;
      logic [OFFSET_W-1:0] start;
      logic [LEN_W-1:0]    length;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    column;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic [KIND_W-1:0] doubled_kind(input logic [BYTE_W-1:0] b);
      logic [KIND_W-1:0] k;
      case (b)
         CH_COLON: k = KIND_DBL_COLON;
         CH_PLUS:  k = KIND_DBL_PLUS;
         CH_MINUS: k = KIND_DBL_MINUS;
         CH_LT:    k = KIND_DBL_LT;
         CH_GT:    k = KIND_DBL_GT;
         CH_EQ:    k = KIND_DBL_EQ;
         CH_AMP:   k = KIND_DBL_AMP;
         CH_BAR:   k = KIND_DBL_BAR;
         default:  k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] equal_kind(input logic [BYTE_W-1:0] b);
      logic [KIND_W-1:0] k;
      case (b)
         CH_LT:      k = KIND_EQ_LT;
         CH_GT:      k = KIND_EQ_GT;
         CH_BANG:    k = KIND_EQ_BANG;
         CH_PLUS:    k = KIND_EQ_PLUS;
         CH_MINUS:   k = KIND_EQ_MINUS;
         CH_STAR:    k = KIND_EQ_STAR;
         CH_SLASH:   k = KIND_EQ_SLASH;
         CH_PERCENT: k = KIND_EQ_PERCENT;
         CH_AMP:     k = KIND_EQ_AMP;
         CH_CARET:   k = KIND_EQ_CARET;
         CH_BAR:     k = KIND_EQ_BAR;
         default:    k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/stt_lexer.sv]
// Scanner state and per-byte token decision: up to two tokens per accepted byte.
`default_nettype none

module stt_lexer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_accept,
   input  wire logic [stt_pkg::BYTE_W-1:0] in_byte,
   output stt_pkg::push_type               push
);
   import stt_pkg::*;

   mode_type              mode_ff, mode_in;
   logic [BYTE_W-1:0]     pending_ff, pending_in;
   logic [OFFSET_W-1:0]   start_ff, start_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ROW_W-1:0]      trow_ff, trow_in;
   logic [COL_W-1:0]      tcol_ff, tcol_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [OFFSET_W-1:0]   pos_ff, pos_in;

   logic [LEN_W-1:0]      len_inc;
   logic                  open_valid;
   logic [KIND_W-1:0]     open_kind;
   logic [LEN_W-1:0]      open_len;
   logic                  other_valid;
   token_type             open_tok;
   token_type             other_tok;
   logic                  restart;
   logic [KIND_W-1:0]     op_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pending_ff <= '0;
         start_ff   <= '0;
         len_ff     <= '0;
         trow_ff    <= ROW_W'(1);
         tcol_ff    <= COL_W'(1);
         row_ff     <= ROW_W'(1);
         col_ff     <= COL_W'(1);
         pos_ff     <= '0;
      end else if (in_accept) begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
         trow_ff    <= trow_in;
         tcol_ff    <= tcol_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         pos_ff     <= pos_in;
      end
   end

   always_comb begin
      if (mode_ff >= MODE_IDENT && mode_ff <= MODE_CHR_ESC && len_ff != LEN_MAX) begin
         len_inc = len_ff + LEN_W'(1);
      end else begin
         len_inc = len_ff;
      end

      op_kind = (in_byte == pending_ff) ? doubled_kind(in_byte) : KIND_NONE;
      if (op_kind == KIND_NONE && in_byte == CH_EQ) begin
         op_kind = equal_kind(pending_ff);
      end
      if (op_kind == KIND_NONE && pending_ff == CH_MINUS && in_byte == CH_GT) begin
         op_kind = KIND_ARROW;
      end

      mode_in     = mode_ff;
      pending_in  = pending_ff;
      start_in    = start_ff;
      len_in      = len_inc;
      trow_in     = trow_ff;
      tcol_in     = tcol_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pos_in      = pos_ff;
      open_valid  = 1'b0;
      open_kind   = KIND_SINGLE;
      open_len    = len_inc;
      other_valid = 1'b0;
      other_tok   = '{kind: KIND_SINGLE, char_byte: in_byte, start: pos_ff,
                      length: LEN_W'(1), row: row_ff, column: col_ff, last: 1'b0};
      restart     = 1'b0;

      if (in_byte == CH_NUL) begin
         open_len = len_ff;
         case (mode_ff)
            MODE_IDENT: begin
               open_valid = 1'b1;
               open_kind  = KIND_IDENT;
            end
            MODE_NUMBER: begin
               open_valid = 1'b1;
               open_kind  = KIND_NUMBER;
            end
            MODE_STR, MODE_STR_ESC: begin
               open_valid = 1'b1;
               open_kind  = KIND_STRING;
            end
            MODE_CHR, MODE_CHR_ESC: begin
               open_valid = 1'b1;
               open_kind  = KIND_CHAR;
            end
            MODE_OP: begin
               open_valid = 1'b1;
               open_kind  = KIND_SINGLE;
            end
            default: begin
            end
         endcase
         other_valid          = 1'b1;
         other_tok.kind       = KIND_END;
         other_tok.char_byte  = CH_NUL;
         other_tok.length     = '0;
         mode_in    = MODE_IDLE;
         pending_in = '0;
         start_in   = '0;
         len_in     = '0;
         trow_in    = ROW_W'(1);
         tcol_in    = COL_W'(1);
         row_in     = ROW_W'(1);
         col_in     = COL_W'(1);
         pos_in     = '0;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!(is_alpha(in_byte) || is_digit(in_byte))) begin
                  open_valid = 1'b1;
                  open_kind  = KIND_IDENT;
                  open_len   = len_inc - LEN_W'(1);
                  restart    = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (!is_digit(in_byte)) begin
                  open_valid = 1'b1;
                  open_kind  = KIND_NUMBER;
                  open_len   = len_inc - LEN_W'(1);
                  restart    = 1'b1;
               end
            end
            MODE_STR: begin
               if (in_byte == CH_BSLASH) begin
                  mode_in = MODE_STR_ESC;
               end else if (in_byte == pending_ff) begin
                  open_valid = 1'b1;
                  open_kind  = KIND_STRING;
                  mode_in    = MODE_IDLE;
               end
            end
            MODE_CHR: begin
               if (in_byte == CH_BSLASH) begin
                  mode_in = MODE_CHR_ESC;
               end else if (in_byte == pending_ff) begin
                  open_valid = 1'b1;
                  open_kind  = KIND_CHAR;
                  mode_in    = MODE_IDLE;
               end
            end
            MODE_STR_ESC: begin
               mode_in = MODE_STR;
            end
            MODE_CHR_ESC: begin
               mode_in = MODE_CHR;
            end
            MODE_OP: begin
               if (op_kind != KIND_NONE) begin
                  open_valid = 1'b1;
                  open_kind  = op_kind;
                  open_len   = LEN_W'(2);
                  len_in     = LEN_W'(2);
                  mode_in    = MODE_IDLE;
               end else if (pending_ff == CH_SLASH && in_byte == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (pending_ff == CH_SLASH && in_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  open_valid = 1'b1;
                  open_kind  = KIND_SINGLE;
                  restart    = 1'b1;
               end
            end
            MODE_LINE: begin
               if (in_byte == CH_NL) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_BLOCK: begin
               if (in_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK_STAR;
               end
            end
            MODE_BLOCK_STAR: begin
               if (in_byte == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (in_byte != CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase

         if (restart) begin
            mode_in = MODE_IDLE;
            if (in_byte > CH_SPACE) begin
               if (is_alpha(in_byte)) begin
                  mode_in = MODE_IDENT;
               end else if (is_digit(in_byte)) begin
                  mode_in = MODE_NUMBER;
               end else if (in_byte == CH_DQUOTE) begin
                  mode_in = MODE_STR;
               end else if (in_byte == CH_SQUOTE) begin
                  mode_in = MODE_CHR;
               end else if (doubled_kind(in_byte) != KIND_NONE ||
                            equal_kind(in_byte) != KIND_NONE) begin
                  mode_in = MODE_OP;
               end else begin
                  other_valid = 1'b1;
               end
               if (!other_valid) begin
                  pending_in = in_byte;
                  start_in   = pos_ff;
                  len_in     = LEN_W'(1);
                  trow_in    = row_ff;
                  tcol_in    = col_ff;
               end
            end
         end

         pos_in = pos_ff + OFFSET_W'(1);
         if (in_byte == CH_NL) begin
            row_in = (row_ff != ROW_MAX) ? row_ff + ROW_W'(1) : row_ff;
            col_in = COL_W'(1);
         end else if (col_ff != COL_MAX) begin
            col_in = col_ff + COL_W'(1);
         end
      end

      open_tok = '{kind: open_kind, char_byte: pending_ff, start: start_ff,
                   length: open_len, row: trow_ff, column: tcol_ff, last: 1'b0};

      push = '0;
      if (in_accept) begin
         if (open_valid && other_valid) begin
            push.count       = 2'd2;
            push.first       = open_tok;
            push.second      = other_tok;
            push.second.last = 1'b1;
         end else if (open_valid) begin
            push.count      = 2'd1;
            push.first      = open_tok;
            push.first.last = 1'b1;
         end else if (other_valid) begin
            push.count      = 2'd1;
            push.first      = other_tok;
            push.first.last = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/stt_fifo.sv]
// Result queue: takes up to two tokens per cycle, hands out one per cycle on pop.
`default_nettype none

module stt_fifo #(
   parameter int unsigned DEPTH = stt_pkg::FIFO_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire stt_pkg::push_type push,
   input  wire logic        pop,
   output stt_pkg::token_type head,
   output logic             not_empty,
   output logic             has_room
);
   import stt_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   token_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;

   function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_next   = ptr_step(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_step(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= CNT_W'(DEPTH - 2);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CNT_W'(DEPTH - 2) && push.count != 2'd3)
      else $error("push into result queue without room");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty result queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0 && !not_empty)
      else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire

[hw/rtl/source_text_tokenizer.sv]
// Top level of the source text tokenizer: byte stream in, token stream out.
//
// Input channel req_*: one source byte per transaction on req_text_byte.
// A byte of zero ends the text: any open token is sent, then an end token
// (kind 0) at the zero byte's position, and the scanner returns to its
// reset state, ready for the next text.
// Output channel rsp_*: one token per transaction; rsp_last marks the last
// token caused by one input byte (a byte causes zero, one or two tokens).
// The tokens a byte completes are written into the result queue when that
// byte is accepted, and are handed out from the queue in order.
// Throughput: one byte per cycle while req_ready is high; the scanner
// decides each byte combinationally from its mode register and one pending
// byte. Tokens queue in a FIFO_DEPTH-entry result queue, drained one per
// cycle while rsp_ready is high; req_ready is high while two entries are free.
// Stall: when rsp_ready is low the queue fills and req_ready drops; nothing
// is lost. Reset (synchronous) empties the queue and clears the scanner:
// row and column 1, offset 0.
`default_nettype none

module source_text_tokenizer #(
   parameter int unsigned FIFO_DEPTH = stt_pkg::FIFO_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [stt_pkg::BYTE_W-1:0]   req_text_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [stt_pkg::KIND_W-1:0]        rsp_token_kind,
   output logic [stt_pkg::BYTE_W-1:0]        rsp_token_char,
   output logic [stt_pkg::OFFSET_W-1:0]      rsp_start_offset,
   output logic [stt_pkg::LEN_W-1:0]         rsp_token_length,
   output logic [stt_pkg::ROW_W-1:0]         rsp_start_row,
   output logic [stt_pkg::COL_W-1:0]         rsp_start_column,
   output logic                              rsp_last
);
   import stt_pkg::*;

   logic      in_accept;
   logic      out_accept;
   logic      has_room;
   logic      not_empty;
   push_type  push;
   token_type head;

   assign in_accept  = req_valid && req_ready;
   assign out_accept = rsp_valid && rsp_ready;

   stt_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_text_byte),
      .push      (push)
   );

   stt_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (out_accept),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign req_ready        = has_room;
   assign rsp_valid        = not_empty;
   assign rsp_token_kind   = head.kind;
   assign rsp_token_char   = head.char_byte;
   assign rsp_start_offset = head.start;
   assign rsp_token_length = head.length;
   assign rsp_start_row    = head.row;
   assign rsp_start_column = head.column;
   assign rsp_last         = head.last;

endmodule

`default_nettype wire

[test/token_checker.sv]
// Token checker: predicts the token stream from accepted source bytes and compares each token.
module token_checker
   import stt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [BYTE_W-1:0]   req_text_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [KIND_W-1:0]   rsp_token_kind,
   input  logic [BYTE_W-1:0]   rsp_token_char,
   input  logic [OFFSET_W-1:0] rsp_start_offset,
   input  logic [LEN_W-1:0]    rsp_token_length,
   input  logic [ROW_W-1:0]    rsp_start_row,
   input  logic [COL_W-1:0]    rsp_start_column,
   input  logic                rsp_last,
   output int                  mismatches,
   output int                  tokens_due,
   output int                  tokens_checked,
   output int                  bytes_taken
);
   timeunit 1ns;
   timeprecision 1ps;

   mode_type              scan;
   logic [BYTE_W-1:0]     open_byte;
   logic [OFFSET_W-1:0]   open_start;
   logic [LEN_W-1:0]      open_len;
   logic [ROW_W-1:0]      open_row;
   logic [COL_W-1:0]      open_col;
   logic [ROW_W-1:0]      row_now;
   logic [COL_W-1:0]      col_now;
   logic [OFFSET_W-1:0]   offset_now;

   token_type awaited_tokens[$];
   int        fail_total = 0;
   int        checked_total = 0;
   int        byte_total = 0;

   function automatic logic is_letter(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] folded;
      folded = b | 8'h20;
      return (folded >= "a" && folded <= "z") || b == "_";
   endfunction

   function automatic logic is_num(input logic [BYTE_W-1:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // kind of the two-byte operator formed by lead then b, KIND_NONE if none
   function automatic logic [KIND_W-1:0] pair_kind(input logic [BYTE_W-1:0] lead,
                                                   input logic [BYTE_W-1:0] b);
      logic [KIND_W-1:0] k;
      k = KIND_NONE;
      if (b == lead) begin
         case (b)
            CH_COLON: k = KIND_DBL_COLON;
            CH_PLUS:  k = KIND_DBL_PLUS;
            CH_MINUS: k = KIND_DBL_MINUS;
            CH_LT:    k = KIND_DBL_LT;
            CH_GT:    k = KIND_DBL_GT;
            CH_EQ:    k = KIND_DBL_EQ;
            CH_AMP:   k = KIND_DBL_AMP;
            CH_BAR:   k = KIND_DBL_BAR;
            default:  k = KIND_NONE;
         endcase
      end
      if (k == KIND_NONE && b == CH_EQ) begin
         case (lead)
            CH_LT:      k = KIND_EQ_LT;
            CH_GT:      k = KIND_EQ_GT;
            CH_BANG:    k = KIND_EQ_BANG;
            CH_PLUS:    k = KIND_EQ_PLUS;
            CH_MINUS:   k = KIND_EQ_MINUS;
            CH_STAR:    k = KIND_EQ_STAR;
            CH_SLASH:   k = KIND_EQ_SLASH;
            CH_PERCENT: k = KIND_EQ_PERCENT;
            CH_AMP:     k = KIND_EQ_AMP;
            CH_CARET:   k = KIND_EQ_CARET;
            CH_BAR:     k = KIND_EQ_BAR;
            default:    k = KIND_NONE;
         endcase
      end
      if (k == KIND_NONE && lead == CH_MINUS && b == CH_GT) k = KIND_ARROW;
      return k;
   endfunction

   function automatic token_type tok(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] ch,
                                     input logic [OFFSET_W-1:0] start,
                                     input logic [LEN_W-1:0] len,
                                     input logic [ROW_W-1:0] row,
                                     input logic [COL_W-1:0] col);
      token_type t;
      t.kind = kind;
      t.char_byte = ch;
      t.start = start;
      t.length = len;
      t.row = row;
      t.column = col;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic token_type open_token(input logic [KIND_W-1:0] kind);
      return tok(kind, open_byte, open_start, open_len, open_row, open_col);
   endfunction

   task automatic clear_scanner();
      scan = MODE_IDLE;
      open_byte = CH_NUL;
      open_start = '0;
      open_len = '0;
      open_row = ROW_W'(1);
      open_col = COL_W'(1);
      row_now = ROW_W'(1);
      col_now = COL_W'(1);
      offset_now = '0;
   endtask

   task automatic open_at(input logic [BYTE_W-1:0] b, input mode_type m);
      scan = m;
      open_byte = b;
      open_start = offset_now;
      open_len = LEN_W'(1);
      open_row = row_now;
      open_col = col_now;
   endtask

   // one source byte: queue the tokens it completes, the final one marked last
   task automatic lex_byte(input logic [BYTE_W-1:0] b);
      token_type         caused[$];
      token_type         t;
      logic              restart;
      logic [KIND_W-1:0] k;
      restart = 1'b0;
      if (b == CH_NUL) begin
         case (scan)
            MODE_IDENT:             caused.push_back(open_token(KIND_IDENT));
            MODE_NUMBER:            caused.push_back(open_token(KIND_NUMBER));
            MODE_STR, MODE_STR_ESC: caused.push_back(open_token(KIND_STRING));
            MODE_CHR, MODE_CHR_ESC: caused.push_back(open_token(KIND_CHAR));
            MODE_OP:                caused.push_back(open_token(KIND_SINGLE));
            default: ;
         endcase
         caused.push_back(tok(KIND_END, CH_NUL, offset_now, '0, row_now, col_now));
         clear_scanner();
      end else begin
         if (scan >= MODE_IDENT && scan <= MODE_CHR_ESC && open_len != LEN_MAX)
            open_len++;
         case (scan)
            MODE_IDENT: begin
               if (!(is_letter(b) || is_num(b))) begin
                  open_len--;
                  caused.push_back(open_token(KIND_IDENT));
                  restart = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (!is_num(b)) begin
                  open_len--;
                  caused.push_back(open_token(KIND_NUMBER));
                  restart = 1'b1;
               end
            end
            MODE_STR, MODE_CHR: begin
               if (b == CH_BSLASH) begin
                  if (scan == MODE_STR) scan = MODE_STR_ESC;
                  else scan = MODE_CHR_ESC;
               end else if (b == open_byte) begin
                  if (scan == MODE_STR) caused.push_back(open_token(KIND_STRING));
                  else caused.push_back(open_token(KIND_CHAR));
                  scan = MODE_IDLE;
               end
            end
            MODE_STR_ESC: scan = MODE_STR;
            MODE_CHR_ESC: scan = MODE_CHR;
            MODE_OP: begin
               k = pair_kind(open_byte, b);
               if (k != KIND_NONE) begin
                  open_len = LEN_W'(2);
                  caused.push_back(open_token(k));
                  scan = MODE_IDLE;
               end else if (open_byte == CH_SLASH && b == CH_SLASH) begin
                  scan = MODE_LINE;
               end else if (open_byte == CH_SLASH && b == CH_STAR) begin
                  scan = MODE_BLOCK;
               end else begin
                  caused.push_back(open_token(KIND_SINGLE));
                  restart = 1'b1;
               end
            end
            MODE_LINE: if (b == CH_NL) scan = MODE_IDLE;
            MODE_BLOCK: if (b == CH_STAR) scan = MODE_BLOCK_STAR;
            MODE_BLOCK_STAR: begin
               if (b == CH_SLASH) scan = MODE_IDLE;
               else if (b != CH_STAR) scan = MODE_BLOCK;
            end
            default: restart = 1'b1;
         endcase
         if (restart) begin
            scan = MODE_IDLE;
            if (b > CH_SPACE) begin
               if (is_letter(b)) open_at(b, MODE_IDENT);
               else if (is_num(b)) open_at(b, MODE_NUMBER);
               else if (b == CH_DQUOTE) open_at(b, MODE_STR);
               else if (b == CH_SQUOTE) open_at(b, MODE_CHR);
               else if (pair_kind(b, b) != KIND_NONE || pair_kind(b, CH_EQ) != KIND_NONE)
                  open_at(b, MODE_OP);
               else caused.push_back(tok(KIND_SINGLE, b, offset_now, LEN_W'(1),
                                         row_now, col_now));
            end
         end
         offset_now++;
         if (b == CH_NL) begin
            if (row_now != ROW_MAX) row_now++;
            col_now = COL_W'(1);
         end else if (col_now != COL_MAX) begin
            col_now++;
         end
      end
      foreach (caused[i]) begin
         t = caused[i];
         t.last = (i == caused.size() - 1);
         awaited_tokens.push_back(t);
      end
   endtask

   task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
      $display("mismatch at token %0d: %s got %0h expected %0h",
               checked_total, what, seen, want);
      fail_total++;
   endtask

   always @(posedge clock) begin : watch
      token_type want;
      if (reset) begin
         clear_scanner();
         awaited_tokens.delete();
      end else begin
         if (req_valid && req_ready) begin
            lex_byte(req_text_byte);
            byte_total++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_tokens.size() == 0) begin
               report("unexpected token, kind", rsp_token_kind, '0);
            end else begin
               want = awaited_tokens.pop_front();
               if (rsp_token_kind !== want.kind) report("kind", rsp_token_kind, want.kind);
               if (rsp_token_char !== want.char_byte)
                  report("char", rsp_token_char, want.char_byte);
               if (rsp_start_offset !== want.start)
                  report("offset", rsp_start_offset, want.start);
               if (rsp_token_length !== want.length)
                  report("length", rsp_token_length, want.length);
               if (rsp_start_row !== want.row) report("row", rsp_start_row, want.row);
               if (rsp_start_column !== want.column)
                  report("column", rsp_start_column, want.column);
               if (rsp_last !== want.last) report("last", rsp_last, want.last);
            end
            checked_total++;
         end
      end
      mismatches <= fail_total;
      tokens_due <= awaited_tokens.size();
      tokens_checked <= checked_total;
      bytes_taken <= byte_total;
   end

endmodule

[test/tb.sv]
// Testbench top for the source text tokenizer: clock, reset, byte stimulus, token sink, verdict.
module tb;
   import stt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 1200;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 4000;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [BYTE_W-1:0]   req_text_byte = '0;
   logic                rsp_ready = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [KIND_W-1:0]   rsp_token_kind;
   logic [BYTE_W-1:0]   rsp_token_char;
   logic [OFFSET_W-1:0] rsp_start_offset;
   logic [LEN_W-1:0]    rsp_token_length;
   logic [ROW_W-1:0]    rsp_start_row;
   logic [COL_W-1:0]    rsp_start_column;
   logic                rsp_last;

   int mismatches;
   int tokens_due;
   int tokens_checked;
   int bytes_taken;

   logic              sender_eager = 1'b0;
   logic              hold_request = 1'b0;
   logic              holding = 1'b0;
   logic [BYTE_W-1:0] text[$];
   int                bytes_sent = 0;

   source_text_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_char   (rsp_token_char),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_column (rsp_start_column),
      .rsp_last         (rsp_last)
   );

   token_checker lex_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_char   (rsp_token_char),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_start_row    (rsp_start_row),
      .rsp_start_column (rsp_start_column),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .tokens_due       (tokens_due),
      .tokens_checked   (tokens_checked),
      .bytes_taken      (bytes_taken)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   // valid stays up into the next transaction when no gap is drawn
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      int r;
      req_text_byte <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      if (!sender_eager) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(4, 25);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text();
      foreach (text[i]) send_byte(text[i]);
      bytes_sent += text.size();
      text.delete();
   endtask

   task automatic add_lexeme();
      int    n;
      int    r;
      string punct;
      punct = "(){}[];,.?~#@$";
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            r = $urandom_range(0, 52);
            if (r < 26) text.push_back("a" + r);
            else if (r < 52) text.push_back("A" + r - 26);
            else text.push_back("_");
            n = $urandom_range(0, 7);
            repeat (n) begin
               r = $urandom_range(0, 62);
               if (r < 26) text.push_back("a" + r);
               else if (r < 52) text.push_back("A" + r - 26);
               else if (r < 62) text.push_back("0" + r - 52);
               else text.push_back("_");
            end
         end
         3: repeat ($urandom_range(1, 6)) text.push_back("0" + $urandom_range(0, 9));
         4, 5: begin
            text.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            n = text.size() - 1;
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 5))
                  0: begin
                     text.push_back(CH_BSLASH);
                     text.push_back($urandom_range(1, 255));
                  end
                  1: text.push_back($urandom_range(128, 255));
                  2: text.push_back(CH_NL);
                  default: text.push_back($urandom_range(32, 126));
               endcase
            end
            text.push_back(text[n]);
         end
         6, 7, 8: begin
            case ($urandom_range(0, 32))
               0: push_str("->");   1: push_str("::");   2: push_str("++");
               3: push_str("--");   4: push_str("<<");   5: push_str(">>");
               6: push_str("==");   7: push_str("&&");   8: push_str("||");
               9: push_str("<=");   10: push_str(">=");  11: push_str("!=");
               12: push_str("+=");  13: push_str("-=");  14: push_str("*=");
               15: push_str("/=");  16: push_str("%=");  17: push_str("&=");
               18: push_str("^=");  19: push_str("|=");  20: push_str(":");
               21: push_str("+");   22: push_str("-");   23: push_str("<");
               24: push_str(">");   25: push_str("=");   26: push_str("&");
               27: push_str("|");   28: push_str("!");   29: push_str("*");
               30: push_str("/");   31: push_str("%");   default: push_str("^");
            endcase
         end
         9: begin
            if ($urandom_range(0, 2) == 0) text.push_back($urandom_range(128, 255));
            else begin
               r = $urandom_range(0, 13);
               text.push_back(punct[r]);
            end
         end
         10: begin
            push_str("//");
            repeat ($urandom_range(0, 6)) text.push_back($urandom_range(32, 255));
            if ($urandom_range(0, 4) != 0) text.push_back(CH_NL);
         end
         11: begin
            push_str("/*");
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 4))
                  0: text.push_back(CH_STAR);
                  1: text.push_back(CH_NL);
                  2: text.push_back(CH_SLASH);
                  default: text.push_back($urandom_range(32, 126));
               endcase
            end
            push_str("*/");
         end
         12: text.push_back($urandom_range(1, 255));
         13: text.push_back($urandom_range(1, 32));
         default: ;
      endcase
      case ($urandom_range(0, 3))
         1: text.push_back(CH_SPACE);
         2: text.push_back(CH_NL);
         3: text.push_back(8'h09);
         default: ;
      endcase
   endtask

   initial begin : receiver
      int  span;
      int  r;
      logic level;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            holding = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holding = 1'b0;
         end else begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
               level = 1'b1;
               span = $urandom_range(1, 40);
            end else if (r < 18) begin
               level = 1'b0;
               span = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               span = $urandom_range(8, 60);
            end
            rsp_ready <= level;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle = 0;
         else idle++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int  start_count;
      logic pressed;
      pressed = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // identifier, escaped string and char, arrow, doubled colon, block comment
      // closed by a bare star-slash, number, line comment, high byte
      push_str("a9\"\\\"\"'\\''->::/**/7//\n");
      text.push_back(8'hFF);
      text.push_back(CH_NUL);
      // text ending inside a literal, on a pending operator, inside a comment, empty
      push_str("\"x");
      text.push_back(CH_NUL);
      push_str("+");
      text.push_back(CH_NUL);
      push_str("/*");
      text.push_back(CH_NUL);
      text.push_back(CH_NUL);
      send_text();

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         if (!pressed && bytes_sent - start_count > 400) begin
            pressed = 1'b1;
            req_valid <= 1'b0;
            hold_request = 1'b1;
            while (!holding) @(posedge clock);
            sender_eager = 1'b1;
            repeat (80) text.push_back(";");
            text.push_back(CH_NUL);
            send_text();
         end
         sender_eager = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 25)) add_lexeme();
         case ($urandom_range(0, 9))
            0: push_str("\"ab");
            1: push_str("/*x");
            2: push_str("'");
            3: push_str("-");
            default: ;
         endcase
         text.push_back(CH_NUL);
         send_text();
      end
      req_valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (tokens_due != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("summary: %0d source bytes lexed, %0d tokens compared", bytes_taken,
               tokens_checked);
      $display("summary: covered literals, comments, operators, text ends and a %0d-cycle stall",
               LONG_HOLD);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
